// ----- hdl/sorted_unique_key_table_macros.svh -----
// assertion macros for the sorted unique-key table
`ifndef SORTED_UNIQUE_KEY_TABLE_MACROS_SVH
`define SORTED_UNIQUE_KEY_TABLE_MACROS_SVH

`ifndef SYNTHESIS
`define SUT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SUT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SUT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SUT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hdl/sut_pkg.sv -----
// types and constants shared by the sorted unique-key table
package sut_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = 5;
  localparam int KEY_W = 32;
  localparam int IDX_IN_W = 4;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_FIND   = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  localparam logic [2:0] STAT_INSERTED  = 3'd0;
  localparam logic [2:0] STAT_DUPLICATE = 3'd1;
  localparam logic [2:0] STAT_FULL      = 3'd2;
  localparam logic [2:0] STAT_FOUND     = 3'd3;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd4;
  localparam logic [2:0] STAT_BAD_INDEX = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } sut_state_t;

  typedef struct packed {
    logic load;
    logic cmp;
    logic upd;
  } sut_cmd_t;

endpackage

// ----- hdl/sut_ctrl.sv -----
// controller state machine for the sorted unique-key table
module sut_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  output sut_pkg::sut_cmd_t  cmd
);

  sut_pkg::sut_state_t state_r, state_nxt;
  logic out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sut_pkg::S_IDLE: begin
        if (start) state_nxt = sut_pkg::S_CMP;
      end
      sut_pkg::S_CMP: begin
        state_nxt = sut_pkg::S_UPD;
      end
      sut_pkg::S_UPD: begin
        // a new request may enter while the last one commits
        if (start) state_nxt = sut_pkg::S_CMP;
        else state_nxt = sut_pkg::S_IDLE;
      end
      default: begin
        state_nxt = sut_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy     = 1'b0;
    cmd.load = 1'b0;
    cmd.cmp  = 1'b0;
    cmd.upd  = 1'b0;
    case (state_r)
      sut_pkg::S_IDLE: begin
        cmd.load = start;
      end
      sut_pkg::S_CMP: begin
        busy    = 1'b1;
        cmd.cmp = 1'b1;
      end
      sut_pkg::S_UPD: begin
        cmd.upd  = 1'b1;
        cmd.load = start;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sut_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.upd;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hdl/sut_datapath.sv -----
// entry cells, key compare and result registers of the sorted unique-key table
module sut_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sut_pkg::sut_cmd_t            cmd,
  input  logic [1:0]                   in_kind,
  input  logic signed [31:0]           in_part_key,
  input  logic                         in_part_type,
  input  logic signed [31:0]           in_attribute,
  input  logic [sut_pkg::IDX_IN_W-1:0] in_index,
  output logic [2:0]                   out_status,
  output logic [sut_pkg::POS_W-1:0]    out_position,
  output logic signed [31:0]           out_found_key,
  output logic                         out_found_type,
  output logic signed [31:0]           out_found_attribute,
  output logic [sut_pkg::POS_W-1:0]    out_entry_count
);

  // latched request
  logic [1:0]                   req_kind_r;
  logic signed [31:0]           req_key_r;
  logic                         req_type_r;
  logic signed [31:0]           req_attr_r;
  logic [sut_pkg::IDX_IN_W-1:0] req_index_r;

  // entry cells
  logic signed [31:0] key_r  [sut_pkg::DEPTH];
  logic               type_r [sut_pkg::DEPTH];
  logic signed [31:0] attr_r [sut_pkg::DEPTH];
  logic [sut_pkg::CNT_W-1:0] count_r, count_nxt;

  // compare vectors
  logic [sut_pkg::DEPTH-1:0] eq_r, eq_nxt, less_r, less_nxt;

  // outcome
  logic                      hit;
  logic [sut_pkg::CNT_W-1:0] hit_pos, lower_pos, sel_pos, pos_nxt;
  logic signed [31:0]        sel_key, sel_attr, fkey_nxt, fattr_nxt;
  logic                      sel_type, ftype_nxt;
  logic [2:0]                status_nxt;
  logic                      ins_go;

  logic [2:0]                   status_r;
  logic [sut_pkg::POS_W-1:0]    pos_r, cnt_out_r;
  logic signed [31:0]           fkey_r, fattr_r;
  logic                         ftype_r;

  always_comb begin
    for (int i = 0; i < sut_pkg::DEPTH; i++) begin
      eq_nxt[i]   = (sut_pkg::CNT_W'(i) < count_r) && (key_r[i] == req_key_r);
      less_nxt[i] = (sut_pkg::CNT_W'(i) < count_r) && (key_r[i] < req_key_r);
    end
  end

  // table is sorted and unique: eq is at most one-hot, less is a prefix
  always_comb begin
    hit       = |eq_r;
    hit_pos   = '0;
    lower_pos = '0;
    for (int i = 0; i < sut_pkg::DEPTH; i++) begin
      if (eq_r[i]) hit_pos = hit_pos | sut_pkg::CNT_W'(i);
      if (less_r[i] && ((i == sut_pkg::DEPTH - 1) || !less_r[(i + 1) % sut_pkg::DEPTH]))
        lower_pos = lower_pos | sut_pkg::CNT_W'(i + 1);
    end
  end

  // a read selects by index, whatever key came with it
  always_comb begin
    sel_pos  = (req_kind_r == sut_pkg::KIND_READ) ? sut_pkg::CNT_W'(req_index_r) : hit_pos;
    sel_key  = '0;
    sel_type = 1'b0;
    sel_attr = '0;
    for (int i = 0; i < sut_pkg::DEPTH; i++) begin
      if (sut_pkg::CNT_W'(i) == sel_pos) begin
        sel_key  = key_r[i];
        sel_type = type_r[i];
        sel_attr = attr_r[i];
      end
    end
  end

  always_comb begin
    status_nxt = sut_pkg::STAT_BAD_INDEX;
    pos_nxt    = '0;
    fkey_nxt   = '0;
    ftype_nxt  = 1'b0;
    fattr_nxt  = '0;
    count_nxt  = count_r;
    ins_go     = 1'b0;
    case (req_kind_r)
      sut_pkg::KIND_INSERT: begin
        if (hit) begin
          status_nxt = sut_pkg::STAT_DUPLICATE;
          pos_nxt    = hit_pos;
          fkey_nxt   = sel_key;
          ftype_nxt  = sel_type;
          fattr_nxt  = sel_attr;
        end else if (count_r == sut_pkg::CNT_W'(sut_pkg::DEPTH)) begin
          status_nxt = sut_pkg::STAT_FULL;
          pos_nxt    = count_r;
        end else begin
          status_nxt = sut_pkg::STAT_INSERTED;
          pos_nxt    = lower_pos;
          fkey_nxt   = req_key_r;
          ftype_nxt  = req_type_r;
          fattr_nxt  = req_attr_r;
          count_nxt  = count_r + 1'b1;
          ins_go     = 1'b1;
        end
      end
      sut_pkg::KIND_FIND: begin
        if (hit) begin
          status_nxt = sut_pkg::STAT_FOUND;
          pos_nxt    = hit_pos;
          fkey_nxt   = sel_key;
          ftype_nxt  = sel_type;
          fattr_nxt  = sel_attr;
        end else begin
          status_nxt = sut_pkg::STAT_NOT_FOUND;
          pos_nxt    = count_r;
        end
      end
      sut_pkg::KIND_READ: begin
        pos_nxt = sut_pkg::CNT_W'(req_index_r);
        if (sut_pkg::CNT_W'(req_index_r) < count_r) begin
          status_nxt = sut_pkg::STAT_FOUND;
          fkey_nxt   = sel_key;
          ftype_nxt  = sel_type;
          fattr_nxt  = sel_attr;
        end
      end
      default: begin
        status_nxt = sut_pkg::STAT_BAD_INDEX;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.upd) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind_r  <= in_kind;
      req_key_r   <= in_part_key;
      req_type_r  <= in_part_type;
      req_attr_r  <= in_attribute;
      req_index_r <= in_index;
    end
    if (cmd.cmp) begin
      eq_r   <= eq_nxt;
      less_r <= less_nxt;
    end
    if (cmd.upd) begin
      status_r  <= status_nxt;
      pos_r     <= sut_pkg::POS_W'(pos_nxt);
      fkey_r    <= fkey_nxt;
      ftype_r   <= ftype_nxt;
      fattr_r   <= fattr_nxt;
      cnt_out_r <= sut_pkg::POS_W'(count_nxt);
    end
  end

  // insert: cells above the slot shift up by one, the slot takes the request
  always_ff @(posedge clk) begin
    if (cmd.upd && ins_go) begin
      for (int i = 0; i < sut_pkg::DEPTH; i++) begin
        if (sut_pkg::CNT_W'(i) == lower_pos) begin
          key_r[i]  <= req_key_r;
          type_r[i] <= req_type_r;
          attr_r[i] <= req_attr_r;
        end else if ((i > 0) && (sut_pkg::CNT_W'(i) > lower_pos)) begin
          key_r[i]  <= key_r[(i + sut_pkg::DEPTH - 1) % sut_pkg::DEPTH];
          type_r[i] <= type_r[(i + sut_pkg::DEPTH - 1) % sut_pkg::DEPTH];
          attr_r[i] <= attr_r[(i + sut_pkg::DEPTH - 1) % sut_pkg::DEPTH];
        end
      end
    end
  end

  assign out_status          = status_r;
  assign out_position        = pos_r;
  assign out_found_key       = fkey_r;
  assign out_found_type      = ftype_r;
  assign out_found_attribute = fattr_r;
  assign out_entry_count     = cnt_out_r;

endmodule

// ----- hdl/sorted_unique_key_table.sv -----
// top level of the sorted unique-key table
//
//   channel  ports                              handshake
//   request  start, busy, in_*                  taken when start && !busy
//   result   out_valid, out_*                   one-cycle strobe, no backpressure
//
// a request first compares the key against every cell at once, in the compare state;
// the update state then shifts the cells on insert and registers the result.
// the result strobe comes in the cycle after the update; a new request can be
// taken during the update cycle, while the last request commits its result.
// reset clears the entry count; cell contents are undefined until written.
// results cannot be stalled.
module sorted_unique_key_table (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_kind,
  input  logic signed [31:0]           in_part_key,
  input  logic                         in_part_type,
  input  logic signed [31:0]           in_attribute,
  input  logic [sut_pkg::IDX_IN_W-1:0] in_index,
  output logic                         out_valid,
  output logic [2:0]                   out_status,
  output logic [sut_pkg::POS_W-1:0]    out_position,
  output logic signed [31:0]           out_found_key,
  output logic                         out_found_type,
  output logic signed [31:0]           out_found_attribute,
  output logic [sut_pkg::POS_W-1:0]    out_entry_count
);

  `include "sorted_unique_key_table_macros.svh"

  sut_pkg::sut_cmd_t cmd;

  sut_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  sut_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_kind             (in_kind),
    .in_part_key         (in_part_key),
    .in_part_type        (in_part_type),
    .in_attribute        (in_attribute),
    .in_index            (in_index),
    .out_status          (out_status),
    .out_position        (out_position),
    .out_found_key       (out_found_key),
    .out_found_type      (out_found_type),
    .out_found_attribute (out_found_attribute),
    .out_entry_count     (out_entry_count)
  );

  // accepted request goes to compare, then a result after the update state
  `SUT_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `SUT_ASSERT_IMPL(a_busy_result, clk, rst_n, busy, ##2 out_valid)
  // every result carries a defined status and a count within the table
  `SUT_ASSERT_IMPL(a_result_range, clk, rst_n, out_valid, (out_status <= sut_pkg::STAT_BAD_INDEX) && (out_entry_count <= sut_pkg::POS_W'(sut_pkg::DEPTH)))

endmodule
